// ===== hw/rtl/mch_pkg.sv =====
package mch_pkg;

   // Histogram geometry.
   localparam int NUM_BINS    = 256;
   localparam int COUNT_WIDTH = 20;
   localparam int BIN_W       = $clog2(NUM_BINS);
   localparam int PIX_W       = 8;
   localparam int OUT_W       = 20;

   // Bin limit compared against a zero-extended pixel or index value.
   localparam logic [PIX_W:0] BIN_LIMIT = (PIX_W + 1)'(NUM_BINS);
   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = {COUNT_WIDTH{1'b1}};

   // Normalized output: Q0.16, so the quotient needs one integer bit on top.
   localparam int FRAC_BITS = 16;
   localparam int QUOT_W    = FRAC_BITS + 1;
   localparam int STEP_W    = $clog2(QUOT_W + 1);

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_CHANNEL_SELECT = 1'b0;
   localparam logic REG_NORMALIZE_MODE = 1'b1;

   // Input opcodes.
   localparam logic [1:0] OP_ACCUM = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Channel select codes.
   localparam logic [1:0] CH_SEL_0 = 2'd0;
   localparam logic [1:0] CH_SEL_1 = 2'd1;
   localparam logic [1:0] CH_SEL_2 = 2'd2;

   typedef enum logic [1:0] {
      CMD_ACC   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type       op;
      logic [BIN_W-1:0] idx;
      logic             oob;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic logic [OUT_W-1:0] fit_out(input logic [63:0] v);
      return v[OUT_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/mch_front.sv =====
module mch_front (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic [mch_pkg::PIX_W-1:0]   req_chan0,
   input  logic [mch_pkg::PIX_W-1:0]   req_chan1,
   input  logic [mch_pkg::PIX_W-1:0]   req_chan2,
   input  logic [mch_pkg::PIX_W-1:0]   req_bin_index,
   input  logic [1:0]                  channel_select,
   input  mch_pkg::q_status_type       q_status,
   output logic                        push,
   output mch_pkg::cmd_type            push_cmd
);
   import mch_pkg::*;

   logic [PIX_W-1:0] sel_val;
   logic             sel_ok;
   logic             keep;

   // Pick the channel that names the bin; an unused select counts nothing.
   always_comb begin
      sel_val = req_chan0;
      sel_ok  = 1'b1;
      unique case (channel_select)
         CH_SEL_0: sel_val = req_chan0;
         CH_SEL_1: sel_val = req_chan1;
         CH_SEL_2: sel_val = req_chan2;
         default:  sel_ok  = 1'b0;
      endcase
   end

   always_comb begin
      keep     = 1'b0;
      push_cmd = '{op: CMD_ACC, idx: sel_val[BIN_W-1:0], oob: 1'b0};
      unique case (req_opcode)
         OP_ACCUM: begin
            keep = sel_ok && ({1'b0, sel_val} < BIN_LIMIT) &&
                   ((req_chan0 | req_chan1 | req_chan2) != '0);
         end
         OP_READ: begin
            keep     = 1'b1;
            push_cmd = '{op: CMD_READ, idx: req_bin_index[BIN_W-1:0],
                         oob: !({1'b0, req_bin_index} < BIN_LIMIT)};
         end
         OP_CLEAR: begin
            keep     = 1'b1;
            push_cmd = '{op: CMD_CLEAR, idx: '0, oob: 1'b0};
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full && keep;

endmodule

// ===== hw/rtl/mch_queue.sv =====
module mch_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mch_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output mch_pkg::cmd_type      head,
   output mch_pkg::q_status_type status
);
   import mch_pkg::*;

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/mch_div.sv =====
module mch_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mch_pkg::COUNT_WIDTH-1:0]   dividend,
   input  logic [mch_pkg::COUNT_WIDTH-1:0]   divisor,
   output logic                              done,
   output logic [mch_pkg::QUOT_W-1:0]        quotient
);
   import mch_pkg::*;

   // Restoring division of dividend * 2^16 by divisor, one quotient bit per
   // cycle. The dividend never exceeds the divisor, so from the integer step on the
   // remainder stays below the divisor.
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] dsr_ff, dsr_in;
   logic [QUOT_W-1:0]      quot_ff, quot_in;
   logic [COUNT_WIDTH:0]   trial;
   logic                   ge;

   always_comb begin
      trial = (step_ff == STEP_W'(QUOT_W)) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      ge    = (trial >= {1'b0, dsr_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(QUOT_W);
         rem_in  = dividend;
         dsr_in  = divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? COUNT_WIDTH'(trial - {1'b0, dsr_ff}) : trial[COUNT_WIDTH-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== hw/rtl/mch_back.sv =====
module mch_back (
   input  logic                          clock,
   input  logic                          reset,
   input  mch_pkg::cmd_type              head,
   input  mch_pkg::q_status_type         q_status,
   output logic                          pop,
   input  logic                          normalize_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mch_pkg::OUT_W-1:0]     rsp_bin_value,
   output logic [mch_pkg::OUT_W-1:0]     rsp_peak_count
);
   import mch_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOOK = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [NUM_BINS-1:0]    valid_ff, valid_in;
   logic [COUNT_WIDTH-1:0] max_ff, max_in;
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic [OUT_W-1:0]       res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]       rsp_bin_ff, rsp_bin_in;
   logic [OUT_W-1:0]       rsp_peak_ff, rsp_peak_in;

   logic [COUNT_WIDTH-1:0] bins_mem [NUM_BINS];
   logic                   mem_we;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   logic [COUNT_WIDTH-1:0] cnt;
   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic                   div_start;
   logic                   div_done;
   logic [QUOT_W-1:0]      div_quot;
   logic                   load;

   mch_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cnt),
      .divisor  (max_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // A bin that has not been written since the last clear reads as zero.
   always_comb begin
      cnt     = (cmd_ff.oob || !valid_ff[cmd_ff.idx]) ? '0 : rd_data_ff;
      cnt_inc = (cnt == COUNT_LIMIT) ? cnt : cnt + 1'b1;
   end

   assign load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign pop  = (state_ff == ST_IDLE) && !q_status.empty;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      valid_in  = valid_ff;
      max_in    = max_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_wdata = cnt_inc;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (head.op == CMD_CLEAR) begin
                  valid_in = '0;
                  max_in   = '0;
               end else begin
                  cmd_in   = head;
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            if (cmd_ff.op == CMD_ACC) begin
               mem_we               = 1'b1;
               valid_in[cmd_ff.idx] = 1'b1;
               if (cnt_inc > max_ff) begin
                  max_in = cnt_inc;
               end
               state_in = ST_IDLE;
            end else if (!normalize_mode) begin
               res_in   = fit_out(64'(cnt));
               state_in = ST_EMIT;
            end else if (max_ff == '0) begin
               res_in   = '0;
               state_in = ST_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = fit_out(64'(div_quot));
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_bin_in   = rsp_bin_ff;
      rsp_peak_in  = rsp_peak_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_bin_in   = res_ff;
         rsp_peak_in  = fit_out(64'(max_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      res_ff      <= res_in;
      rsp_bin_ff  <= rsp_bin_in;
      rsp_peak_ff <= rsp_peak_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bins_mem[cmd_ff.idx] <= mem_wdata;
      end
      if (pop) begin
         rd_data_ff <= bins_mem[head.idx];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_value  = rsp_bin_ff;
   assign rsp_peak_count = rsp_peak_ff;

endmodule

// ===== hw/rtl/masked_channel_histogram.sv =====
// Masked channel histogram: counts one selected channel of three-channel pixels.
// Request beats (req_) carry an opcode: accumulate a pixel, read a bin or clear
// all bins. Only a read produces a response beat (rsp_) with the bin's count, or
// count / peak as Q0.16 in normalize mode, together with the current peak count.
// Black pixels, pixels under an unused channel select and unused opcodes vanish
// in the front and never reach the queue. Channel select and normalize mode sit
// behind the APB-style csr_ port; the user must write them only while the block is
// idle, and the block itself does not enforce it. With the back idle, a queued
// accumulate is popped in the idle state, its bin is read into a register and the
// incremented count is written back in the look state; a raw read passes idle, look
// and emit, and a normalized read also waits in the divide state for the 17-step
// serial divider. The bin memory is read and written in separate states, so the
// back takes a new command only once it is back in idle. A clear is done in the
// idle state. Reset clears the per-bin valid flags at once, so there is no clearing
// pass and items are taken straight after reset. While the receiver stalls, the
// response beat holds; the back part carries on until the next read needs the output
// register, and req_stall rises once the queue is full.
module masked_channel_histogram (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_opcode,
   input  logic [mch_pkg::PIX_W-1:0]         req_chan0,
   input  logic [mch_pkg::PIX_W-1:0]         req_chan1,
   input  logic [mch_pkg::PIX_W-1:0]         req_chan2,
   input  logic [mch_pkg::PIX_W-1:0]         req_bin_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mch_pkg::OUT_W-1:0]         rsp_bin_value,
   output logic [mch_pkg::OUT_W-1:0]         rsp_peak_count,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mch_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mch_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mch_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import mch_pkg::*;

   logic [1:0]   chan_sel_ff, chan_sel_in;
   logic         norm_ff, norm_in;
   logic         csr_wr;
   logic         reg_idx;

   logic         push;
   cmd_type      push_cmd;
   cmd_type      head;
   q_status_type q_status;
   logic         pop;

   // Registers are word-aligned; bit 2 of the address picks one of the two.
   assign reg_idx = csr_paddr[2];
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      chan_sel_in = chan_sel_ff;
      norm_in     = norm_ff;
      if (csr_wr) begin
         if (reg_idx == REG_CHANNEL_SELECT) begin
            chan_sel_in = csr_pwdata[1:0];
         end else begin
            norm_in = csr_pwdata[0];
         end
      end
   end

   always_comb begin
      if (reg_idx == REG_CHANNEL_SELECT) begin
         csr_prdata = CSR_DATA_W'(chan_sel_ff);
      end else begin
         csr_prdata = CSR_DATA_W'(norm_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_sel_ff <= CH_SEL_0;
         norm_ff     <= 1'b0;
      end else begin
         chan_sel_ff <= chan_sel_in;
         norm_ff     <= norm_in;
      end
   end

   // The front classifies each beat and drops the ones that change nothing.
   mch_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_chan0      (req_chan0),
      .req_chan1      (req_chan1),
      .req_chan2      (req_chan2),
      .req_bin_index  (req_bin_index),
      .channel_select (chan_sel_ff),
      .q_status       (q_status),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // The queue lets the front keep taking beats while the back is busy.
   mch_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // The back owns the bin memory, the peak count, the divider and the
   // response register.
   mch_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .normalize_mode (norm_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bin_value  (rsp_bin_value),
      .rsp_peak_count (rsp_peak_count)
   );

endmodule

// ===== hw/rtl/mch_checker.sv =====
module mch_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [mch_pkg::OUT_W-1:0]         rsp_bin_value,
   input logic [mch_pkg::OUT_W-1:0]         rsp_peak_count,
   input logic                              csr_pready
);
   import mch_pkg::*;

   // A stalled response beat stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // A stalled response beat keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_bin_value) && $stable(rsp_peak_count))
      else $error("response payload changed while stalled");

   // With an empty histogram every read gives zero, whatever the mode.
   a_zero_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_peak_count == '0) |-> (rsp_bin_value == '0))
      else $error("non-zero bin value with zero peak");

   // No response can be pending in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // The configuration port never inserts wait states.
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("configuration port not ready");

endmodule

bind masked_channel_histogram mch_checker u_mch_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_bin_value  (rsp_bin_value),
   .rsp_peak_count (rsp_peak_count),
   .csr_pready     (csr_pready)
);

// ===== sim/histogram_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, response and register ports of the histogram block, keeps its own
// copy of the bins, the peak and the two settings, and compares every response beat with
// the oldest reading still due.
module histogram_checker
   import mch_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic [PIX_W-1:0]      req_chan0,
   input  logic [PIX_W-1:0]      req_chan1,
   input  logic [PIX_W-1:0]      req_chan2,
   input  logic [PIX_W-1:0]      req_bin_index,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [OUT_W-1:0]      rsp_bin_value,
   input  logic [OUT_W-1:0]      rsp_peak_count,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    error_count,
   output int                    results_owed,
   output int                    results_checked,
   output int                    pixels_binned
);

   typedef struct packed {
      logic [OUT_W-1:0] bin_value;
      logic [OUT_W-1:0] peak_count;
   } reading_type;

   reading_type            readings_due[$];
   logic [COUNT_WIDTH-1:0] tally [NUM_BINS];
   logic [COUNT_WIDTH-1:0] tally_peak;
   logic [1:0]             sel_chan;
   logic                   norm_on;
   int                     mismatches;
   int                     checked;
   int                     binned;

   function automatic reading_type predict_reading(input logic [PIX_W-1:0] idx);
      reading_type            r;
      logic [COUNT_WIDTH-1:0] cnt;
      logic [63:0]            scaled;
      cnt = (idx < NUM_BINS) ? tally[idx] : '0;
      if (!norm_on)
         scaled = 64'(cnt);
      else if (tally_peak == '0)
         scaled = '0;
      else
         scaled = (64'(cnt) << FRAC_BITS) / 64'(tally_peak);
      r.bin_value  = scaled[OUT_W-1:0];
      r.peak_count = OUT_W'(tally_peak);
      return r;
   endfunction

   task automatic bin_pixel(input logic [PIX_W-1:0] c0, c1, c2);
      logic [PIX_W-1:0] v;
      // Black pixels are masked out before any channel is looked at.
      if ({c0, c1, c2} == '0)
         return;
      case (sel_chan)
         CH_SEL_0: v = c0;
         CH_SEL_1: v = c1;
         CH_SEL_2: v = c2;
         default: return;
      endcase
      if (v >= NUM_BINS)
         return;
      if (tally[v] != COUNT_LIMIT)
         tally[v] = tally[v] + 1'b1;
      if (tally[v] > tally_peak)
         tally_peak = tally[v];
      binned++;
   endtask

   always @(posedge clock) begin
      reading_type due;
      if (reset) begin
         for (int k = 0; k < NUM_BINS; k++)
            tally[k] = '0;
         tally_peak = '0;
         sel_chan   = CH_SEL_0;
         norm_on    = 1'b0;
         readings_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (readings_due.size() == 0) begin
               mismatches++;
               $error("response beat with no read outstanding: bin_value %0d, peak_count %0d",
                      rsp_bin_value, rsp_peak_count);
            end else begin
               due = readings_due.pop_front();
               checked++;
               if (rsp_bin_value !== due.bin_value) begin
                  mismatches++;
                  $error("bin_value: expected %0d, got %0d", due.bin_value, rsp_bin_value);
               end
               if (rsp_peak_count !== due.peak_count) begin
                  mismatches++;
                  $error("peak_count: expected %0d, got %0d", due.peak_count, rsp_peak_count);
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_opcode)
               OP_ACCUM: bin_pixel(req_chan0, req_chan1, req_chan2);
               OP_READ:  readings_due.push_back(predict_reading(req_bin_index));
               OP_CLEAR: begin
                  for (int k = 0; k < NUM_BINS; k++)
                     tally[k] = '0;
                  tally_peak = '0;
               end
               default: ;
            endcase
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[1:0] == 2'b00) begin
            if (csr_paddr[CSR_ADDR_W-1:2] == REG_CHANNEL_SELECT)
               sel_chan = csr_pwdata[1:0];
            else if (csr_paddr[CSR_ADDR_W-1:2] == REG_NORMALIZE_MODE)
               norm_on = csr_pwdata[0];
         end
      end
      error_count     <= mismatches;
      results_owed    <= readings_due.size();
      results_checked <= checked;
      pixels_binned   <= binned;
   end

endmodule

// ===== sim/tb_masked_channel_histogram.sv =====
`timescale 1ns / 1ps

module tb_masked_channel_histogram;
   import mch_pkg::*;

   // Even with every beat a normalised read under heavy stalls and long gaps, a correct
   // run ends well within the limit, which leaves a wide margin.
   localparam int CYCLE_LIMIT     = 500_000;
   localparam int RANDOM_ITEMS    = 1500;
   localparam int PHASES          = 8;
   // Cycles allowed after the last response for queued accumulates and clears to retire.
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_READS  = 40;

   // Opcode 3 and channel select 3 have no name in the package; both must do nothing.
   localparam logic [1:0] OP_SPARE    = 2'd3;
   localparam logic [1:0] CH_SEL_NONE = 2'd3;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_style_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_opcode    = OP_ACCUM;
   logic [PIX_W-1:0]      req_chan0     = '0;
   logic [PIX_W-1:0]      req_chan1     = '0;
   logic [PIX_W-1:0]      req_chan2     = '0;
   logic [PIX_W-1:0]      req_bin_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [OUT_W-1:0]      rsp_bin_value;
   logic [OUT_W-1:0]      rsp_peak_count;
   logic                  csr_psel      = 1'b0;
   logic                  csr_penable   = 1'b0;
   logic                  csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata    = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int error_count;
   int results_owed;
   int results_checked;
   int pixels_binned;

   int  cycle_count   = 0;
   int  beats_sent    = 0;
   int  writes_done   = 0;
   int  burst_left    = 0;
   bit  hold_off_go   = 1'b0;
   bit  hold_off_done = 1'b0;

   // A few favoured values per phase, so that some bins grow tall and reads hit them.
   logic [PIX_W-1:0] hot_bins [4];

   masked_channel_histogram uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_chan0      (req_chan0),
      .req_chan1      (req_chan1),
      .req_chan2      (req_chan2),
      .req_bin_index  (req_bin_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bin_value  (rsp_bin_value),
      .rsp_peak_count (rsp_peak_count),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   histogram_checker hist_watch (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_chan0       (req_chan0),
      .req_chan1       (req_chan1),
      .req_chan2       (req_chan2),
      .req_bin_index   (req_bin_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bin_value   (rsp_bin_value),
      .rsp_peak_count  (rsp_peak_count),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .error_count     (error_count),
      .results_owed    (results_owed),
      .results_checked (results_checked),
      .pixels_binned   (pixels_binned)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a run that hangs on a handshake ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver. It changes its stall style after a random stretch: no stall at all, light
   // or heavy random stalls, or a fixed pattern, so that stalls land on every phase of a
   // read. Once asked, it holds off for one long stretch so that the response register,
   // then the command queue and finally the request port all back up.
   initial begin : receiver
      stall_style_type style;
      int              style_left;
      style      = STALL_NONE;
      style_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_go && !hold_off_done) begin
            rsp_stall = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_done = 1'b1;
         end
         if (style_left == 0) begin
            style      = stall_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(32, 200);
         end
         style_left--;
         case (style)
            STALL_NONE:     rsp_stall = 1'b0;
            STALL_LIGHT:    rsp_stall = ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: rsp_stall = (style_left % 5 < 2);
            default:        rsp_stall = ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Presents one request beat at the falling edge and holds it, unchanged, until the
   // block takes it at a rising edge with req_stall low.
   task automatic send_item(input logic [1:0] op, input logic [PIX_W-1:0] c0, c1, c2, idx);
      @(negedge clock);
      req_valid     = 1'b1;
      req_opcode    = op;
      req_chan0     = c0;
      req_chan1     = c1;
      req_chan2     = c2;
      req_bin_index = idx;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   // Drops valid for a number of cycles. The payload wanders meanwhile, which the block
   // must ignore.
   task automatic pause(input int cycles);
      @(negedge clock);
      req_valid     = 1'b0;
      req_opcode    = 2'($urandom());
      req_chan0     = PIX_W'($urandom());
      req_chan1     = PIX_W'($urandom());
      req_chan2     = PIX_W'($urandom());
      req_bin_index = PIX_W'($urandom());
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Sends a beat as part of a burst; at the end of each burst comes a gap and a fresh
   // burst length. Now and then a burst is long enough to be a stretch without idling.
   task automatic offer(input logic [1:0] op, input logic [PIX_W-1:0] c0, c1, c2, idx);
      send_item(op, c0, c1, c2, idx);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 10);
         pause(($urandom_range(0, 9) == 0) ? $urandom_range(6, 25) : $urandom_range(1, 5));
      end
   endtask

   // Waits until every read has been answered, then gives queued accumulates and clears
   // time to retire, so that the block is idle.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write: a setup phase, then an access phase held until pready.
   task automatic csr_write(input logic reg_idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'({reg_idx, 2'b00});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      writes_done++;
   endtask

   // Both registers are rewritten on every change, with junk in the unused upper bits.
   task automatic configure(input logic [1:0] sel, input logic norm);
      settle();
      csr_write(REG_CHANNEL_SELECT, {30'($urandom()), sel});
      csr_write(REG_NORMALIZE_MODE, {31'($urandom()), norm});
   endtask

   function automatic logic [PIX_W-1:0] pixel_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4)
         return hot_bins[$urandom_range(0, 3)];
      else if (roll == 4)
         return '0;
      else
         return PIX_W'($urandom());
   endfunction

   // One random beat. Mostly pixels and reads, with the odd clear, black pixel and
   // unused opcode.
   task automatic random_item();
      int               roll;
      logic [1:0]       op;
      logic [PIX_W-1:0] c0, c1, c2, idx;
      roll = $urandom_range(0, 99);
      c0   = pixel_value();
      c1   = pixel_value();
      c2   = pixel_value();
      idx  = ($urandom_range(0, 2) != 0) ? hot_bins[$urandom_range(0, 3)]
                                        : PIX_W'($urandom());
      if (roll < 4) begin
         op = OP_ACCUM;
         c0 = '0;
         c1 = '0;
         c2 = '0;
      end else if (roll < 62) begin
         op = OP_ACCUM;
      end else if (roll < 94) begin
         op = OP_READ;
      end else if (roll < 97) begin
         op = OP_CLEAR;
      end else begin
         op = OP_SPARE;
      end
      offer(op, c0, c1, c2, idx);
   endtask

   initial begin : stimulus
      int random_count;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed beats under the reset settings: raw counts, channel 0.
      send_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'd0);   // empty histogram
      send_item(OP_ACCUM, 8'd0,   8'd0,   8'd0,   8'd0);   // black pixel, skipped
      send_item(OP_ACCUM, 8'd255, 8'd0,   8'd0,   8'd0);   // top bin
      send_item(OP_ACCUM, 8'd0,   8'd255, 8'd255, 8'd0);   // selected channel zero, not black
      send_item(OP_ACCUM, 8'd255, 8'd170, 8'd85,  8'd0);
      send_item(OP_SPARE, 8'd255, 8'd255, 8'd255, 8'd255); // unused opcode
      send_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'd255);
      send_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'd0);
      send_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'd128);
      send_item(OP_CLEAR, 8'd0,   8'd0,   8'd0,   8'd0);
      send_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'd255);

      // Normalised reads on channel 1, starting with a zero peak.
      configure(CH_SEL_1, 1'b1);
      send_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'd7);
      repeat (3) send_item(OP_ACCUM, 8'd0, 8'd7, 8'd0, 8'd0);
      send_item(OP_ACCUM, 8'd0,   8'd9,   8'd3,   8'd0);
      send_item(OP_ACCUM, 8'd200, 8'd0,   8'd0,   8'd0);   // lands in bin 0
      send_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'd7);   // equal to the peak
      send_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'd9);
      send_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'd0);

      // With the unused channel select no pixel is counted.
      configure(CH_SEL_NONE, 1'b0);
      send_item(OP_ACCUM, 8'd5,   8'd5,   8'd5,   8'd0);
      send_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'd5);

      configure(CH_SEL_2, 1'b0);
      send_item(OP_ACCUM, 8'd0,   8'd0,   8'd200, 8'd0);
      send_item(OP_ACCUM, 8'd1,   8'd1,   8'd255, 8'd0);
      send_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'd200);
      send_item(OP_READ,  8'd0,   8'd0,   8'd0,   8'd255);

      // Random phases across every channel select, raw and normalised.
      for (int p = 0; p < PHASES; p++) begin
         configure(2'(p % 4), (p >= PHASES / 2));
         for (int k = 0; k < 4; k++)
            hot_bins[k] = PIX_W'($urandom());
         hot_bins[0] = (p % 2 == 1) ? '1 : '0;
         random_count = RANDOM_ITEMS / PHASES;
         if (p == 1) begin
            // Long receiver hold-off while reads keep coming, so the queue fills and the
            // request port stalls.
            hold_off_go = 1'b1;
            repeat (HOLD_OFF_READS)
               send_item(OP_READ, 8'd0, 8'd0, 8'd0, hot_bins[$urandom_range(0, 3)]);
            random_count = random_count - HOLD_OFF_READS;
         end
         repeat (random_count) random_item();
      end

      settle();

      $display("Run covered %0d request beats, %0d pixels binned, %0d read responses checked,",
               beats_sent, pixels_binned, results_checked);
      $display("  %0d register writes, all channel selects, raw and normalised reads.",
               writes_done);
      if (error_count == 0 && results_owed == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== masked_channel_histogram.f =====
hw/rtl/mch_pkg.sv
hw/rtl/mch_front.sv
hw/rtl/mch_queue.sv
hw/rtl/mch_div.sv
hw/rtl/mch_back.sv
hw/rtl/masked_channel_histogram.sv
hw/rtl/mch_checker.sv
sim/histogram_checker.sv
sim/tb_masked_channel_histogram.sv
